/* rtl/core/ittl_pkg.sv */
// ittl_pkg: shared types and constants for the ttl rewrite / source counter
// no dependencies
`default_nettype none
package ittl_pkg;
  localparam int TableEntries = 16;
  localparam int IdxW = $clog2(TableEntries);
  localparam logic [13:0] MinFrameLen = 14'd34;
  localparam logic [15:0] EtherTypeIpv4 = 16'h0800;

  // classified item passed from front to back
  typedef struct packed {
    logic        counted;
    logic [31:0] source_address;
    logic [7:0]  ttl;
    logic [15:0] checksum;
  } ittl_cls_t;

  // one's-complement 16-bit add
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    s = {1'b0, s[15:0]} + {16'd0, s[16]};
    return s[15:0];
  endfunction
endpackage
`default_nettype wire

/* rtl/core/ipv4_ttl_rewrite_source_counter_top.sv */
// ipv4_ttl_rewrite_source_counter_top: top level joining front and back
// depends on ittl_pkg, ittl_front, ittl_back
// Takes one item per cycle while in_stall is low: the front rewrites ttl and
// checksum and queues the item in a two-entry buffer, the back matches the
// source against a 16-entry fully associative lru table and registers the
// result, so an item passes the queue buffer and then the result register
// before out_valid rises. Sustained throughput is one item per cycle while
// out_stall is low, as the table is matched and updated as each item is taken.
`default_nettype none
module ipv4_ttl_rewrite_source_counter_top (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [13:0] in_frame_length,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [31:0] in_source_address,
  input  wire logic [7:0]  in_ttl_in,
  input  wire logic [15:0] in_checksum_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_counted,
  output logic [7:0]       out_ttl_out,
  output logic [15:0]      out_checksum_out,
  output logic [31:0]      out_packet_count,
  output logic             out_evicted,
  output logic [31:0]      out_evicted_address
);
  import ittl_pkg::*;

  logic      q_valid, q_stall;
  ittl_cls_t q_item;

  // front: classify and rewrite
  ittl_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_frame_length, .in_ether_type,
    .in_source_address, .in_ttl_in, .in_checksum_in,
    .q_valid, .q_stall, .q_item
  );

  // back: table update and output
  ittl_back u_back (
    .clk, .rst_n, .q_valid, .q_stall, .q_item,
    .out_valid, .out_stall, .out_counted, .out_ttl_out, .out_checksum_out,
    .out_packet_count, .out_evicted, .out_evicted_address
  );
endmodule
`default_nettype wire

/* rtl/core/ittl_front.sv */
// ittl_front: accepts items, classifies them and rewrites ttl and checksum
// depends on ittl_pkg
`default_nettype none
module ittl_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [13:0]         in_frame_length,
  input  wire logic [15:0]         in_ether_type,
  input  wire logic [31:0]         in_source_address,
  input  wire logic [7:0]          in_ttl_in,
  input  wire logic [15:0]         in_checksum_in,
  output logic                     q_valid,
  input  wire logic                q_stall,
  output ittl_pkg::ittl_cls_t      q_item
);
  import ittl_pkg::*;

  ittl_cls_t cls;
  logic [7:0]  nttl;
  logic [15:0] sum;

  // classify and apply rfc 1624 update
  always_comb begin
    cls.counted = (in_frame_length >= MinFrameLen) && (in_ether_type == EtherTypeIpv4);
    cls.source_address = in_source_address;
    nttl = in_ttl_in - 8'd1;
    sum = oc_add(~in_checksum_in, ~{in_ttl_in, 8'd0});
    sum = ~oc_add(sum, {nttl, 8'd0});
    cls.ttl = cls.counted ? nttl : in_ttl_in;
    cls.checksum = cls.counted ? sum : in_checksum_in;
  end

  // two-entry queue toward the back
  ittl_cls_t buf_r [2];
  logic      wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && !q_stall;
  assign q_item = buf_r[rp_r];

  always_comb begin
    wp_nxt = push ? ~wp_r : wp_r;
    rp_nxt = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0;
      rp_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wp_r] <= cls;
    end
  end
endmodule
`default_nettype wire

/* rtl/core/ittl_back.sv */
// ittl_back: lru source table update and result register
// depends on ittl_pkg
`default_nettype none
module ittl_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                q_valid,
  output logic                     q_stall,
  input  wire ittl_pkg::ittl_cls_t q_item,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic                     out_counted,
  output logic [7:0]               out_ttl_out,
  output logic [15:0]              out_checksum_out,
  output logic [31:0]              out_packet_count,
  output logic                     out_evicted,
  output logic [31:0]              out_evicted_address
);
  import ittl_pkg::*;

  logic [31:0]     addr_r  [TableEntries];
  logic [31:0]     count_r [TableEntries];
  logic [TableEntries-1:0] valid_r, valid_nxt;
  logic [IdxW-1:0] age_r [TableEntries];
  logic [IdxW-1:0] age_nxt [TableEntries];

  logic take;
  logic hit, freef;
  logic [IdxW-1:0] hidx, fidx, vidx, tidx, oldage;
  logic [31:0] newcnt;

  // result register frees when taken
  assign q_stall = out_valid && out_stall;
  assign take = q_valid && !q_stall;

  // parallel match, free search and oldest search
  always_comb begin
    hit = 1'b0; hidx = '0; freef = 1'b0; fidx = '0; vidx = '0;
    for (int i = TableEntries - 1; i >= 0; i--) begin
      if (valid_r[i] && addr_r[i] == q_item.source_address) begin
        hit = 1'b1; hidx = IdxW'(i);
      end
      if (!valid_r[i]) begin
        freef = 1'b1; fidx = IdxW'(i);
      end
      if (age_r[i] == IdxW'(TableEntries - 1)) vidx = IdxW'(i);
    end
    tidx = hit ? hidx : (freef ? fidx : vidx);
    oldage = age_r[tidx];
    newcnt = hit ? count_r[hidx] + 32'd1 : 32'd1;
    valid_nxt = valid_r;
    valid_nxt[tidx] = 1'b1;
    for (int i = 0; i < TableEntries; i++) begin
      if (IdxW'(i) == tidx) age_nxt[i] = '0;
      else if (age_r[i] < oldage) age_nxt[i] = age_r[i] + IdxW'(1);
      else age_nxt[i] = age_r[i];
    end
  end

  // control state: valid bits, ages, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < TableEntries; i++) age_r[i] <= IdxW'(i);
    end else begin
      if (take) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      if (take && q_item.counted) begin
        valid_r <= valid_nxt;
        age_r <= age_nxt;
      end
    end
  end

  // table payload and result fields
  always_ff @(posedge clk) begin
    if (take) begin
      if (q_item.counted) begin
        addr_r[tidx] <= q_item.source_address;
        count_r[tidx] <= newcnt;
      end
      out_counted <= q_item.counted;
      out_ttl_out <= q_item.ttl;
      out_checksum_out <= q_item.checksum;
      out_packet_count <= q_item.counted ? newcnt : 32'd0;
      out_evicted <= q_item.counted && !hit && !freef;
      out_evicted_address <= (q_item.counted && !hit && !freef) ? addr_r[vidx] : 32'd0;
    end
  end
endmodule
`default_nettype wire

/* tb/tb_ttl_counter_checker.sv */
// tb_ttl_counter_checker: watches both channels of the ttl rewrite / source
// counter, predicts each result with its own lru table and compares
// depends on ittl_pkg for the table size and frame constants
`default_nettype none
module tb_ttl_counter_checker (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [13:0] in_frame_length,
  input  wire logic [15:0] in_ether_type,
  input  wire logic [31:0] in_source_address,
  input  wire logic [7:0]  in_ttl_in,
  input  wire logic [15:0] in_checksum_in,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic        out_counted,
  input  wire logic [7:0]  out_ttl_out,
  input  wire logic [15:0] out_checksum_out,
  input  wire logic [31:0] out_packet_count,
  input  wire logic        out_evicted,
  input  wire logic [31:0] out_evicted_address,
  output int               fail_count,
  output int               pending_count
);
  import ittl_pkg::*;

  typedef struct packed {
    logic        counted;
    logic [7:0]  ttl;
    logic [15:0] csum;
    logic [31:0] count;
    logic        evicted;
    logic [31:0] ev_addr;
  } rewrite_t;

  rewrite_t rewrite_q[$];

  // shadow lru table
  logic [31:0] src_tab[TableEntries];
  logic [31:0] cnt_tab[TableEntries];
  logic        vld_tab[TableEntries];
  int          rank_tab[TableEntries];

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = a + b;
    return s[15:0] + s[16];
  endfunction

  function automatic void promote(input int idx);
    int old;
    old = rank_tab[idx];
    for (int i = 0; i < TableEntries; i++)
      if (rank_tab[i] < old) rank_tab[i]++;
    rank_tab[idx] = 0;
  endfunction

  function automatic rewrite_t rewrite_frame(input logic [13:0] flen, input logic [15:0] et,
                                             input logic [31:0] src, input logic [7:0] ttl,
                                             input logic [15:0] hc);
    rewrite_t r;
    int slot;
    bit hit;
    r = '0;
    if (flen < MinFrameLen || et != EtherTypeIpv4) begin
      r.ttl = ttl;
      r.csum = hc;
      return r;
    end
    r.counted = 1'b1;
    r.ttl = ttl - 8'd1;
    // incremental checksum: ~(~hc + ~m + m'), protocol byte cancels
    r.csum = ~ones_add(ones_add(~hc, ~{ttl, 8'h00}), {r.ttl, 8'h00});
    hit = 0;
    slot = -1;
    for (int i = 0; i < TableEntries; i++)
      if (!hit && vld_tab[i] && src_tab[i] == src) begin
        hit = 1;
        slot = i;
      end
    if (hit) begin
      cnt_tab[slot] = cnt_tab[slot] + 32'd1;
      r.count = cnt_tab[slot];
    end else begin
      for (int i = 0; i < TableEntries; i++)
        if (slot < 0 && !vld_tab[i]) slot = i;
      if (slot < 0) begin
        slot = 0;
        for (int i = 1; i < TableEntries; i++)
          if (rank_tab[i] > rank_tab[slot]) slot = i;
        r.evicted = 1'b1;
        r.ev_addr = src_tab[slot];
      end
      src_tab[slot] = src;
      cnt_tab[slot] = 32'd1;
      vld_tab[slot] = 1'b1;
      r.count = 32'd1;
    end
    promote(slot);
    return r;
  endfunction

  initial begin
    fail_count = 0;
    for (int i = 0; i < TableEntries; i++) begin
      vld_tab[i] = 1'b0;
      rank_tab[i] = i;
    end
  end

  assign pending_count = rewrite_q.size();

  // predict on input, compare on output
  always @(posedge clk) begin
    rewrite_t got, want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        rewrite_q.push_back(rewrite_frame(in_frame_length, in_ether_type, in_source_address,
                                          in_ttl_in, in_checksum_in));
      if (out_valid && !out_stall) begin
        got = '{out_counted, out_ttl_out, out_checksum_out, out_packet_count, out_evicted,
                out_evicted_address};
        if (rewrite_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected item: %p", got);
        end else begin
          want = rewrite_q.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10) $display("mismatch: expected %p, actual %p", want, got);
          end
        end
      end
    end
  end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// tb_top: stimulus and verdict for the ttl rewrite / source counter
// depends on ittl_pkg, ipv4_ttl_rewrite_source_counter_top, tb_ttl_counter_checker
`default_nettype none
module tb_top;
  import ittl_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [13:0] in_frame_length;
  logic [15:0] in_ether_type;
  logic [31:0] in_source_address;
  logic [7:0]  in_ttl_in;
  logic [15:0] in_checksum_in;
  logic        out_valid;
  logic        out_stall;
  logic        out_counted;
  logic [7:0]  out_ttl_out;
  logic [15:0] out_checksum_out;
  logic [31:0] out_packet_count;
  logic        out_evicted;
  logic [31:0] out_evicted_address;
  int          fail_count;
  int          pending_count;
  logic [31:0] src_pool[24];

  ipv4_ttl_rewrite_source_counter_top dut (.*);
  tb_ttl_counter_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // overall limit
  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic int gap_len();
    if ($urandom_range(0, 9) < 7) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(5, 40);
  endfunction

  // send one item, wait for it to be taken, then idle for a random gap
  task automatic send_frame(input logic [13:0] fl, input logic [15:0] et,
                            input logic [31:0] src, input logic [7:0] ttl,
                            input logic [15:0] hc);
    int g;
    in_valid <= 1'b1;
    in_frame_length <= fl;
    in_ether_type <= et;
    in_source_address <= src;
    in_ttl_in <= ttl;
    in_checksum_in <= hc;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // receiver stall pattern, with a quiet stretch now and then
  initial begin
    int n;
    out_stall = 1'b0;
    @(posedge rst_n);
    forever begin
      n = gap_len();
      out_stall <= (n != 0);
      repeat (n == 0 ? $urandom_range(1, 30) : n) @(posedge clk);
    end
  end

  initial begin
    logic [31:0] src;
    logic [15:0] et;
    logic [13:0] fl;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_frame_length = '0;
    in_ether_type = '0;
    in_source_address = '0;
    in_ttl_in = '0;
    in_checksum_in = '0;
    for (int i = 0; i < 24; i++) src_pool[i] = $urandom();
    src_pool[0] = 32'h0;
    src_pool[1] = 32'hffff_ffff;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: length and ethertype edges, ttl wrap, checksum edges
    send_frame(14'd33, EtherTypeIpv4, 32'h1, 8'd64, 16'h1234);
    send_frame(14'd34, 16'h0801, 32'h1, 8'd64, 16'h1234);
    send_frame(14'd34, EtherTypeIpv4, 32'h0, 8'd0, 16'h0000);
    send_frame(14'h3fff, EtherTypeIpv4, 32'hffff_ffff, 8'd255, 16'hffff);
    send_frame(14'd34, EtherTypeIpv4, 32'h0, 8'd1, 16'hfeff);
    send_frame(14'd0, 16'hffff, 32'hffff_ffff, 8'd255, 16'hffff);
    send_frame(14'd100, EtherTypeIpv4, 32'h0, 8'd128, 16'h00ff);
    // fill past 16 entries to force evictions
    for (int i = 2; i < 20; i++)
      send_frame(14'd60, EtherTypeIpv4, src_pool[i], 8'($urandom()), 16'($urandom()));
    send_frame(14'd60, EtherTypeIpv4, src_pool[5], 8'd10, 16'h8000);

    // random: mostly counted frames from a small pool of sources
    repeat (700) begin
      src = ($urandom_range(0, 9) < 8) ? src_pool[$urandom_range(0, 23)] : $urandom();
      et = ($urandom_range(0, 9) < 8) ? EtherTypeIpv4 : 16'($urandom());
      fl = ($urandom_range(0, 9) < 8) ? 14'($urandom_range(34, 1600)) : 14'($urandom());
      send_frame(fl, et, src, 8'($urandom()), 16'($urandom()));
    end
    in_valid <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
